### rtl/lrgd_pkg.sv
// Shared types, constants and helpers for the gradient-descent trainer.
// No dependencies; imported by the trainer top level.
package lrgd_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW = 16;
  localparam logic [CfgW-1:0] LrReset = 16'd3277;
  localparam logic [CfgW-1:0] IterReset = 16'd1000;
  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_ITERATION_COUNT = 1'b1;
  localparam logic [30:0] RmseMax = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_MUL0,
    ST_MUL1,
    ST_RES,
    ST_SQ,
    ST_G0,
    ST_G1,
    ST_G1W,
    ST_UMUL,
    ST_ULOAD,
    ST_UDIV,
    ST_UW,
    ST_MLOAD,
    ST_MDIV,
    ST_SQLD,
    ST_SQRT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/lrgd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module lrgd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/linear_regression_gd_trainer_unit.sv
// Linear regression trainer: sample store, shared multiplier, divider and root sequencer.
// Depends on lrgd_pkg and lrgd_ram.
//
// Usage: a sample is taken as a transaction when start_i is high and busy_o is low.
// Samples without last_i are stored as they are taken; a sample that arrives when the
// store already holds MAX_SAMPLES entries is dropped. A sample with last_i starts
// training on the n stored samples and busy_o stays high until the result is out.
// Training is paced by one 33x33 multiplier used five times for each sample and a
// one-bit-per-cycle 64-bit divider used for each weight step; at the end come the mean
// division and the 32-step square root, skipped with rmse_o saturated when the mean
// is too large. The result (weight_0_o, weight_1_o, rmse_o) is shown for one cycle with
// done_o; the receiver cannot stall it. busy_o falls with done_o.
// Configuration writes through cfg_we_i are taken in any cycle and belong to idle
// time only. Reset clears the control state and the sample count and sets the
// registers to their defaults; the sample store needs no clearing.
module linear_regression_gd_trainer_unit #(
  parameter int unsigned MAX_SAMPLES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [31:0]          feature_0_i,
  input  logic signed [31:0]          feature_1_i,
  input  logic signed [31:0]          target_i,
  input  logic                        last_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lrgd_pkg::CfgW-1:0]   cfg_wdata_i,
  output logic                        done_o,
  output logic signed [31:0]          weight_0_o,
  output logic signed [31:0]          weight_1_o,
  output logic [30:0]                 rmse_o
);
  import lrgd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_SAMPLES);

  state_e state_q, state_d;
  logic [CfgW-1:0] lr_q, iter_cfg_q, iter_q;
  logic [CW-1:0] cnt_q, n_q, idx_q;
  logic signed [31:0] w0_q, w1_q, r_q;
  logic signed [47:0] p0_q;
  logic signed [63:0] prod_q, sum0_q, sum1_q;
  logic [63:0] err_q;
  logic k_q, neg_q;
  logic [63:0] quo_q;
  logic [CW-1:0] rem_q;
  logic [5:0] dcnt_q;
  logic [63:0] sv_q, sres_q, sbit_q;

  logic accept, wr_en;
  logic [63:0] feat_rd;
  logic [31:0] tgt_rd;
  logic signed [31:0] f0, f1, tgt;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [48:0] pred;
  logic signed [31:0] resid, sum_sat, w_cur, w_new;
  logic signed [32:0] mag;
  logic [CW:0] rem_sh;
  logic div_ge;
  logic [63:0] sq_t;
  logic sq_ge;
  logic [31:0] wstep;

  assign accept = start_i && !busy_o;
  assign wr_en = accept && (cnt_q < MaxCount);
  assign busy_o = (state_q != ST_IDLE);

  lrgd_ram #(.WIDTH(64), .DEPTH(MAX_SAMPLES)) u_feat_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i({feature_1_i, feature_0_i}),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(feat_rd)
  );

  lrgd_ram #(.WIDTH(32), .DEPTH(MAX_SAMPLES)) u_tgt_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(cnt_q[AW-1:0]),
    .wdata_i(target_i),
    .raddr_i(idx_q[AW-1:0]),
    .rdata_o(tgt_rd)
  );

  assign f0 = feat_rd[31:0];
  assign f1 = feat_rd[63:32];
  assign tgt = tgt_rd;

  assign sum_sat = sat32(k_q ? sum1_q : sum0_q);
  assign mag = sum_sat[31] ? -{sum_sat[31], sum_sat} : {sum_sat[31], sum_sat};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL0: begin
        mul_a = {w0_q[31], w0_q};
        mul_b = {f0[31], f0};
      end
      ST_MUL1: begin
        mul_a = {w1_q[31], w1_q};
        mul_b = {f1[31], f1};
      end
      ST_SQ: begin
        mul_a = {r_q[31], r_q};
        mul_b = {r_q[31], r_q};
      end
      ST_G0: begin
        mul_a = {r_q[31], r_q};
        mul_b = {f0[31], f0};
      end
      ST_G1: begin
        mul_a = {r_q[31], r_q};
        mul_b = {f1[31], f1};
      end
      ST_UMUL: begin
        mul_a = mag;
        mul_b = {17'd0, lr_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign pred = {p0_q[47], p0_q} + {prod_q[63], prod_q[63:16]};
  assign resid = sat32(64'(sat32({{15{pred[48]}}, pred})) - {{32{tgt[31]}}, tgt});

  assign rem_sh = {rem_q, quo_q[63]};
  assign div_ge = (rem_sh >= {1'b0, n_q});

  assign sq_t = sres_q + sbit_q;
  assign sq_ge = (sv_q >= sq_t);

  assign wstep = quo_q[47:16];
  assign w_cur = k_q ? w1_q : w0_q;
  assign w_new = sat32(neg_q ? ({{32{w_cur[31]}}, w_cur} + {32'd0, wstep})
                             : ({{32{w_cur[31]}}, w_cur} - {32'd0, wstep}));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && last_i) state_d = ST_RD;
      ST_RD:    state_d = ST_MUL0;
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_RES;
      ST_RES:   state_d = ST_SQ;
      ST_SQ:    state_d = ST_G0;
      ST_G0:    state_d = ST_G1;
      ST_G1:    state_d = ST_G1W;
      ST_G1W:   state_d = (idx_q == n_q - CW'(1)) ? ST_UMUL : ST_RD;
      ST_UMUL:  state_d = ST_ULOAD;
      ST_ULOAD: state_d = ST_UDIV;
      ST_UDIV:  if (dcnt_q == 6'd63) state_d = ST_UW;
      ST_UW: begin
        if (!k_q) begin
          state_d = ST_UMUL;
        end else if (iter_q == CfgW'(1)) begin
          state_d = ST_MLOAD;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_MLOAD: state_d = ST_MDIV;
      ST_MDIV:  if (dcnt_q == 6'd63) state_d = ST_SQLD;
      ST_SQLD:  state_d = (quo_q[63:46] != '0) ? ST_IDLE : ST_SQRT;
      ST_SQRT:  if (sbit_q[0]) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lr_q <= LrReset;
      iter_cfg_q <= IterReset;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_LEARNING_RATE) begin
          lr_q <= cfg_wdata_i;
        end else begin
          iter_cfg_q <= cfg_wdata_i;
        end
      end
      if (wr_en) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == ST_IDLE && accept && last_i) begin
        cnt_q <= '0;
      end
      if ((state_q == ST_SQLD && quo_q[63:46] != '0) || (state_q == ST_SQRT && sbit_q[0])) begin
        done_o <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[63:0];
    case (state_q)
      ST_IDLE: begin
        if (accept && last_i) begin
          n_q <= wr_en ? cnt_q + CW'(1) : cnt_q;
          iter_q <= (iter_cfg_q == '0) ? CfgW'(1) : iter_cfg_q;
          w0_q <= '0;
          w1_q <= '0;
          idx_q <= '0;
          sum0_q <= '0;
          sum1_q <= '0;
          err_q <= '0;
          k_q <= 1'b0;
        end
      end
      ST_MUL1: p0_q <= prod_q[63:16];
      ST_RES:  r_q <= resid;
      ST_G0:   err_q <= err_q + {16'd0, prod_q[63:16]};
      ST_G1:   sum0_q <= sum0_q + {{16{prod_q[63]}}, prod_q[63:16]};
      ST_G1W: begin
        sum1_q <= sum1_q + {{16{prod_q[63]}}, prod_q[63:16]};
        if (idx_q != n_q - CW'(1)) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      ST_UMUL: neg_q <= sum_sat[31];
      ST_ULOAD, ST_MLOAD: begin
        quo_q <= (state_q == ST_ULOAD) ? prod_q : err_q;
        rem_q <= '0;
        dcnt_q <= '0;
      end
      ST_UDIV, ST_MDIV: begin
        quo_q <= {quo_q[62:0], div_ge};
        rem_q <= div_ge ? CW'(rem_sh - {1'b0, n_q}) : rem_sh[CW-1:0];
        dcnt_q <= dcnt_q + 6'd1;
      end
      ST_UW: begin
        if (k_q) begin
          w1_q <= w_new;
          k_q <= 1'b0;
          iter_q <= iter_q - CfgW'(1);
          if (iter_q != CfgW'(1)) begin
            idx_q <= '0;
            sum0_q <= '0;
            sum1_q <= '0;
            err_q <= '0;
          end
        end else begin
          w0_q <= w_new;
          k_q <= 1'b1;
        end
      end
      ST_SQLD: begin
        sv_q <= {quo_q[47:0], 16'd0};
        sres_q <= '0;
        sbit_q <= 64'd1 << 62;
        weight_0_o <= w0_q;
        weight_1_o <= w1_q;
        rmse_o <= RmseMax;
      end
      ST_SQRT: begin
        if (sq_ge) begin
          sv_q <= sv_q - sq_t;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
        if (sbit_q[0]) begin
          rmse_o <= sq_ge ? 31'((sres_q >> 1) + sbit_q) : 31'(sres_q >> 1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/lrgd_checker.sv
// Port-level checker for the trainer top level, attached by a bind statement.
// Depends only on the ports of linear_regression_gd_trainer_unit.
module lrgd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic last_i,
  input logic busy_o,
  input logic done_o
);

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe lasted more than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while still busy");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o)
    else $error("final sample did not start training");

  a_plain_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !(start_i && last_i)) |=> !busy_o)
    else $error("busy without a final sample transaction");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_o) |-> $past(busy_o)) else $error("result without training");

endmodule

bind linear_regression_gd_trainer_unit lrgd_checker u_lrgd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start_i),
  .last_i (last_i),
  .busy_o (busy_o),
  .done_o (done_o)
);

### test/linear_regression_gd_trainer_unit_test.sv
// Self-checking testbench for the gradient-descent linear regression trainer.
// Drives sample batches and register writes, predicts each trained result in
// place and compares it field by field. Depends on lrgd_pkg and the trainer RTL.
`timescale 1ns / 1ps

module linear_regression_gd_trainer_unit_test;
  import lrgd_pkg::*;

  localparam int MaxSamples = 256;

  typedef struct {
    logic signed [31:0] w0;
    logic signed [31:0] w1;
    logic [30:0]        rmse;
  } fit_t;

  typedef struct {
    logic signed [31:0] f0;
    logic signed [31:0] f1;
    logic signed [31:0] tgt;
    logic               last;
    logic               typed;
    fit_t               fit;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] feature_0_i = '0;
  logic signed [31:0] feature_1_i = '0;
  logic signed [31:0] target_i = '0;
  logic last_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic done_o;
  logic signed [31:0] weight_0_o;
  logic signed [31:0] weight_1_o;
  logic [30:0] rmse_o;

  linear_regression_gd_trainer_unit u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("timeout waiting for trainer");
    $display("CHECK FAILED");
    $finish;
  end

  // Predictor state.
  longint     pend_f0[MaxSamples];
  longint     pend_f1[MaxSamples];
  longint     pend_tgt[MaxSamples];
  int         pend_count = 0;
  logic [15:0] lr_q = LrReset;
  logic [15:0] iters_q = IterReset;

  fit_t fit_q[$];
  int   errors = 0;
  int   items = 0;
  int   fits_seen = 0;
  int   dropped = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic fit_t fit_batch();
    fit_t o;
    longint w[2];
    longint resid[MaxSamples];
    longint unsigned err;
    longint unsigned mag;
    longint unsigned stp;
    longint unsigned mse;
    longint p;
    longint sum;
    int n;
    int loops;
    n = (pend_count == 0) ? 1 : pend_count;
    w[0] = 0;
    w[1] = 0;
    err = 0;
    loops = (iters_q == 0) ? 1 : iters_q;
    repeat (loops) begin
      err = 0;
      for (int i = 0; i < n; i++) begin
        p = ((w[0] * pend_f0[i]) >>> 16) + ((w[1] * pend_f1[i]) >>> 16);
        resid[i] = clamp32(clamp32(p) - pend_tgt[i]);
        mag = (resid[i] < 0) ? -resid[i] : resid[i];
        err += (mag * mag) >> 16;
      end
      for (int k = 0; k < 2; k++) begin
        sum = 0;
        for (int i = 0; i < n; i++) begin
          sum += (resid[i] * ((k == 0) ? pend_f0[i] : pend_f1[i])) >>> 16;
        end
        sum = clamp32(sum);
        mag = (sum < 0) ? -sum : sum;
        stp = ((mag * lr_q) / n) >> 16;
        w[k] = clamp32((sum < 0) ? w[k] + longint'(stp) : w[k] - longint'(stp));
      end
    end
    mse = err / n;
    o.w0 = w[0][31:0];
    o.w1 = w[1][31:0];
    if (mse >= (64'd1 << 46)) o.rmse = RmseMax;
    else o.rmse = 31'(int_sqrt(mse << 16));
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Updates the predictor with one accepted sample.
  task automatic take_sample(row_t r);
    fit_t f;
    if (pend_count < MaxSamples) begin
      pend_f0[pend_count] = r.f0;
      pend_f1[pend_count] = r.f1;
      pend_tgt[pend_count] = r.tgt;
      pend_count++;
    end else begin
      dropped++;
    end
    if (r.last) begin
      f = fit_batch();
      if (r.typed) begin
        if (f.w0 != r.fit.w0) report("typed weight_0 vs predictor", f.w0, r.fit.w0);
        if (f.w1 != r.fit.w1) report("typed weight_1 vs predictor", f.w1, r.fit.w1);
        if (f.rmse != r.fit.rmse) report("typed rmse vs predictor", f.rmse, r.fit.rmse);
      end
      fit_q.push_back(r.typed ? r.fit : f);
      pend_count = 0;
    end
  endtask

  always @(posedge clk_i) begin
    fit_t e;
    if (rst_ni && done_o) begin
      fits_seen++;
      if (fit_q.size() == 0) begin
        report("unexpected result, weight_0", weight_0_o, 0);
      end else begin
        e = fit_q.pop_front();
        if (weight_0_o !== e.w0) report("weight_0", weight_0_o, e.w0);
        if (weight_1_o !== e.w1) report("weight_1", weight_1_o, e.w1);
        if (rmse_o !== e.rmse) report("rmse", rmse_o, e.rmse);
      end
    end
  end

  // Called right after a posedge; one transaction per call.
  task automatic send(row_t r, int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i <= 1'b1;
    feature_0_i <= r.f0;
    feature_1_i <= r.f1;
    target_i <= r.tgt;
    last_i <= r.last;
    #1;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    take_sample(r);
    items++;
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (fit_q.size() != 0 || busy_o) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LEARNING_RATE) lr_q = val;
    else iters_q = val;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_field();
    if ($urandom_range(0, 1)) return $urandom;
    return $signed($urandom_range(0, 524287)) - 32'sd262144;
  endfunction

  function automatic row_t rand_row(logic last);
    row_t r;
    r.f0 = rand_field();
    r.f1 = rand_field();
    r.tgt = rand_field();
    r.last = last;
    r.typed = 1'b0;
    r.fit = '{default: '0};
    return r;
  endfunction

  function automatic row_t mk(int f0, int f1, int tgt, logic last);
    row_t r;
    r.f0 = f0;
    r.f1 = f1;
    r.tgt = tgt;
    r.last = last;
    r.typed = 1'b0;
    r.fit = '{default: '0};
    return r;
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    int settings_lr[6] = '{0, 65535, 3277, 1, 40000, 65535};
    int settings_it[6] = '{1, 1, 0, 3, 2, 4};
    int phase;
    int batches;
    int size;
    int mode;
    int guard;
    bit full_done;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_ITERATION_COUNT, 16'd2);

    // All-zero sample: nothing to learn.
    r = mk(0, 0, 0, 1'b1);
    r.typed = 1'b1;
    r.fit = '{w0: 32'sd0, w1: 32'sd0, rmse: 31'd0};
    rows.push_back(r);
    // Zero features with target 1.0: weights stay zero and the error is 1.0.
    r = mk(0, 0, 32'sd65536, 1'b1);
    r.typed = 1'b1;
    r.fit = '{w0: 32'sd0, w1: 32'sd0, rmse: 31'd65536};
    rows.push_back(r);
    rows.push_back(mk(0, 0, 32'h8000_0000, 1'b1));
    rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    rows.push_back(mk(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b1));
    rows.push_back(mk(32'sd65536, 32'sd131072, 32'sd327680, 1'b0));
    rows.push_back(mk(32'sd131072, -32'sd65536, 32'sd65536, 1'b0));
    rows.push_back(mk(-32'sd196608, 32'sd65536, -32'sd327680, 1'b1));
    rows.push_back(mk(32'sd32768, 32'sd16384, 32'sd8192, 1'b1));
    foreach (rows[i]) send(rows[i], $urandom_range(0, 15));

    // Register extremes, a 200-iteration phase, then random settings; one phase fills the store past its end.
    phase = 0;
    full_done = 1'b0;
    while (items < 1300) begin
      if (phase < 6) begin
        write_reg(CFG_LEARNING_RATE, 16'(settings_lr[phase]));
        write_reg(CFG_ITERATION_COUNT, 16'(settings_it[phase]));
      end else if (phase == 6) begin
        write_reg(CFG_ITERATION_COUNT, 16'd200);
      end else begin
        write_reg(CFG_LEARNING_RATE, 16'($urandom_range(0, 65535)));
        write_reg(CFG_ITERATION_COUNT, 16'($urandom_range(0, 4)));
      end
      mode = $urandom_range(0, 3);
      if (phase == 8 && !full_done) begin
        write_reg(CFG_ITERATION_COUNT, 16'd1);
        for (int i = 0; i < MaxSamples + 4; i++) begin
          send(rand_row(i == MaxSamples + 3), (mode == 0) ? 0 : $urandom_range(0, 15));
        end
        full_done = 1'b1;
      end
      batches = (phase == 6) ? 2 : $urandom_range(6, 12);
      for (int b = 0; b < batches; b++) begin
        size = (phase == 6) ? 2 : $urandom_range(1, 8);
        if ($urandom_range(0, 9) == 0) begin
          // Noise ahead of the batch: a lone unmarked sample joins it.
          send(rand_row(1'b0), $urandom_range(0, 15));
        end
        for (int i = 0; i < size; i++) begin
          send(rand_row(i == size - 1), (mode == 0) ? 0 : $urandom_range(0, 15));
        end
      end
      phase++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    guard = 0;
    while (fit_q.size() != 0 && guard < 4_000_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (fit_q.size() != 0) begin
      $display("%0d results never arrived", fit_q.size());
      errors++;
    end

    $display("%0d samples sent over %0d register phases, %0d fits checked, %0d dropped",
             items, phase, fits_seen, dropped);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lrgd_pkg.sv
rtl/lrgd_ram.sv
rtl/linear_regression_gd_trainer_unit.sv
rtl/lrgd_checker.sv
test/linear_regression_gd_trainer_unit_test.sv
